@@ hdl/mm4_pkg.sv @@
`timescale 1ns / 1ps
package mm4_pkg;

  localparam int DIM_DEFAULT = 4;
  localparam int ELEM_W      = 32;
  localparam int COORD_W     = 2;
  localparam int OP_W        = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int FRAC_W      = 16;

  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST,
    CMD_LOAD_SECOND,
    CMD_MULTIPLY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [ELEM_W-1:0]  value;
  } cmd_t;

endpackage

@@ hdl/mm4_front.sv @@
`timescale 1ns / 1ps
module mm4_front #(
  parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mm4_pkg::OP_W-1:0]           operation,
  input  logic [mm4_pkg::COORD_W-1:0]        row,
  input  logic [mm4_pkg::COORD_W-1:0]        column,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  element,
  output logic                               push_valid,
  input  logic                               push_ready,
  output mm4_pkg::cmd_t                      push_cmd,
  output logic [$clog2(DIM*DIM)-1:0]         push_idx
);

  localparam int AW = $clog2(DIM * DIM);
  localparam logic [AW-1:0] DIM_A = AW'(DIM);

  logic keep;
  logic in_range;

  assign in_range = (int'(row) < DIM) && (int'(column) < DIM);

  always_comb begin
    push_cmd.value = element;
    push_cmd.kind  = mm4_pkg::CMD_MULTIPLY;
    keep           = 1'b0;
    case (operation)
      mm4_pkg::OP_LOAD_FIRST: begin
        push_cmd.kind = mm4_pkg::CMD_LOAD_FIRST;
        keep          = in_range;
      end
      mm4_pkg::OP_LOAD_SECOND: begin
        push_cmd.kind = mm4_pkg::CMD_LOAD_SECOND;
        keep          = in_range;
      end
      mm4_pkg::OP_MULTIPLY: begin
        push_cmd.kind = mm4_pkg::CMD_MULTIPLY;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // drop unused codes and out-of-range loads without touching the queue
  assign push_idx   = AW'(row) * DIM_A + AW'(column);
  assign push_valid = in_valid && keep;
  assign in_ready   = push_ready;

endmodule

@@ hdl/mm4_queue.sv @@
`timescale 1ns / 1ps
module mm4_queue #(
  parameter int W     = 8,
  parameter int DEPTH = mm4_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  logic [W-1:0]    slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/mm4_back.sv @@
`timescale 1ns / 1ps
module mm4_back #(
  parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  mm4_pkg::cmd_t                      q_cmd,
  input  logic [$clog2(DIM*DIM)-1:0]         q_idx,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mm4_pkg::COORD_W-1:0]        out_row,
  output logic [mm4_pkg::COORD_W-1:0]        out_column,
  output logic signed [mm4_pkg::ELEM_W-1:0]  product_element,
  output logic                               last
);

  localparam int AW     = $clog2(DIM * DIM);
  localparam int CW     = $clog2(DIM);
  localparam int EW     = mm4_pkg::ELEM_W;
  localparam int PRW    = mm4_pkg::PROD_W;
  localparam int ACC_W  = PRW + $clog2(DIM);
  localparam int SW     = ACC_W - mm4_pkg::FRAC_W;
  localparam int CRW    = mm4_pkg::COORD_W;
  localparam logic [AW-1:0] DIM_A    = AW'(DIM);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIM - 1);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  typedef struct packed {
    logic          valid;
    logic          first_k;
    logic          last_k;
    logic          last_elem;
    logic [CW-1:0] r;
    logic [CW-1:0] c;
  } tag_t;

  state_t        state;
  logic [CW-1:0] r;
  logic [CW-1:0] c;
  logic [CW-1:0] k;
  logic          en;
  logic          wr_a;
  logic          wr_b;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  tag_t          issue_tag;

  logic signed [EW-1:0]  mem_a [DIM*DIM];
  logic signed [EW-1:0]  mem_b [DIM*DIM];
  logic signed [EW-1:0]  rd_a;
  logic signed [EW-1:0]  rd_b;
  logic signed [PRW-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [SW-1:0]  shifted;
  logic                  fits;
  logic signed [EW-1:0]  sat_value;

  tag_t          s1_tag;
  tag_t          s2_tag;
  logic          acc_valid;
  logic          acc_last;
  logic [CW-1:0] acc_r;
  logic [CW-1:0] acc_c;

  // whole pipeline holds while the output word waits
  assign en      = !out_valid || out_ready;
  assign q_ready = (state == S_IDLE);
  assign wr_a    = q_valid && q_ready && (q_cmd.kind == mm4_pkg::CMD_LOAD_FIRST);
  assign wr_b    = q_valid && q_ready && (q_cmd.kind == mm4_pkg::CMD_LOAD_SECOND);
  assign a_addr  = AW'(r) * DIM_A + AW'(k);
  assign b_addr  = AW'(k) * DIM_A + AW'(c);

  always_comb begin
    issue_tag.valid     = (state == S_RUN);
    issue_tag.first_k   = (k == '0);
    issue_tag.last_k    = (k == CNT_LAST);
    issue_tag.last_elem = (r == CNT_LAST) && (c == CNT_LAST);
    issue_tag.r         = r;
    issue_tag.c         = c;
  end

  // sequencer: walk r, c, k with k innermost
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_cmd.kind == mm4_pkg::CMD_MULTIPLY) begin
            state <= S_RUN;
            r     <= '0;
            c     <= '0;
            k     <= '0;
          end
        end
        S_RUN: begin
          if (en) begin
            if (k == CNT_LAST) begin
              k <= '0;
              if (c == CNT_LAST) begin
                c <= '0;
                if (r == CNT_LAST) begin
                  r     <= '0;
                  state <= S_IDLE;
                end else begin
                  r <= r + 1'b1;
                end
              end else begin
                c <= c + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[q_idx] <= q_cmd.value;
    end
    if (en) begin
      rd_a <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[q_idx] <= q_cmd.value;
    end
    if (en) begin
      rd_b <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag    <= '0;
      s2_tag    <= '0;
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_tag    <= issue_tag;
      s2_tag    <= s1_tag;
      acc_valid <= s2_tag.valid && s2_tag.last_k;
      out_valid <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= rd_a * rd_b;
      if (s2_tag.valid) begin
        acc      <= s2_tag.first_k ? ACC_W'(prod) : acc + ACC_W'(prod);
        acc_last <= s2_tag.last_elem;
        acc_r    <= s2_tag.r;
        acc_c    <= s2_tag.c;
      end
      out_row         <= CRW'(acc_r);
      out_column      <= CRW'(acc_c);
      last            <= acc_last;
      product_element <= sat_value;
    end
  end

  // floor shift, then clamp to 32 bits
  assign shifted = acc[ACC_W-1:mm4_pkg::FRAC_W];
  assign fits    = (shifted[SW-1:EW-1] == {(SW-EW+1){shifted[EW-1]}});

  always_comb begin
    if (fits) begin
      sat_value = shifted[EW-1:0];
    end else if (shifted[SW-1]) begin
      sat_value = {1'b1, {(EW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(EW-1){1'b1}}};
    end
  end

endmodule

@@ hdl/matrix4x4_multiply.sv @@
`timescale 1ns / 1ps
// Multiplies two DIM x DIM matrices of signed Q16.16 values.
// Input channel (in_valid/in_ready): each word loads one element of the
// first matrix (operation 0) or the second (operation 1) at row/column, or
// requests the product (operation 2). Code 3 and out-of-range loads are
// accepted and dropped. Loads emit nothing.
// Output channel (out_valid/out_ready): a product request yields DIM*DIM
// words in row-major order, last set on the final one. Each element is the
// sum of DIM full products, shifted right by 16 (floor), clamped to 32 bits.
// A two-entry queue sits between the input side and the compute side, so
// words keep being accepted while products are being worked out.
// A load is written into its matrix memory as it is popped. A product request
// is popped, then its terms go one per cycle, while no output word is stalled,
// through a shared multiply-accumulate unit fed by one read port on
// each matrix memory.
// Each term passes the memory read registers, the product register and the
// accumulator; each element, the sum of DIM terms, then goes to the output register.
// When an output word waits with out_ready low, the compute pipeline holds and
// the queue fills; in_ready drops once the queue is full. Nothing is lost.
// Reset empties the queue and pipeline; matrix contents are undefined until
// loaded.
module matrix4x4_multiply #(
  parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mm4_pkg::OP_W-1:0]           operation,
  input  logic [mm4_pkg::COORD_W-1:0]        row,
  input  logic [mm4_pkg::COORD_W-1:0]        column,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  element,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mm4_pkg::COORD_W-1:0]        out_row,
  output logic [mm4_pkg::COORD_W-1:0]        out_column,
  output logic signed [mm4_pkg::ELEM_W-1:0]  product_element,
  output logic                               last
);

  localparam int AW = $clog2(DIM * DIM);
  localparam int QW = $bits(mm4_pkg::cmd_t) + AW;

  logic          push_valid;
  logic          push_ready;
  mm4_pkg::cmd_t push_cmd;
  logic [AW-1:0] push_idx;
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;
  mm4_pkg::cmd_t q_cmd;
  logic [AW-1:0] q_idx;

  mm4_front #(
    .DIM(DIM)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .row        (row),
    .column     (column),
    .element    (element),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_idx   (push_idx)
  );

  mm4_queue #(
    .W     (QW),
    .DEPTH (mm4_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_idx}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_cmd = q_data[QW-1:AW];
  assign q_idx = q_data[AW-1:0];

  mm4_back #(
    .DIM(DIM)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_cmd           (q_cmd),
    .q_idx           (q_idx),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_column      (out_column),
    .product_element (product_element),
    .last            (last)
  );

endmodule
